// ----- src/sca_pkg.sv -----
// Package for the seed chain accept block: reject codes, register indexes and shared types.
// No dependencies.
package sca_pkg;

   typedef enum logic [2:0] {
      RSN_NONE   = 3'd0,
      RSN_ORIENT = 3'd1,
      RSN_ENDED  = 3'd2,
      RSN_BAND   = 3'd3,
      RSN_AGE    = 3'd4,
      RSN_INVERT = 3'd5,
      RSN_DIAM   = 3'd6,
      RSN_RADIUS = 3'd7
   } reason_type;

   localparam logic [2:0] CSR_DIAG_HALF_BIN = 3'd0;
   localparam logic [2:0] CSR_MAX_RADIUS    = 3'd1;
   localparam logic [2:0] CSR_MAX_DIAMETER  = 3'd2;
   localparam logic [2:0] CSR_ANCIENT_AGE   = 3'd3;
   localparam logic [2:0] CSR_OLD_AGE       = 3'd4;

   localparam int CSR_DATA_W = 20;

endpackage

// ----- src/seed_chain_accept.sv -----
// Seed chain accept: tests each seed against one read's chain and keeps the diagonal table.
// Depends on sca_pkg.
//
//  channel | ports                      | handshake
//  req     | req_kind .. req_seed_span  | start & !busy
//  rsp     | rsp_accepted .. overflow   | rsp_valid, one cycle, no stall
//  csr     | csr_we, csr_index, csr_data| csr_we, while idle
//
// A clear goes to ST_DONE, which registers its word out. A seed scans the table one entry
// a cycle from the key/offset memory, whose read is registered, then decides in ST_DECIDE:
// a rejected seed's word goes out through ST_DONE, an accepted one first passes ST_PRUNE and
// ST_WRITE.
// busy covers the word's cycle too, so the next item is taken in the cycle after it.
// Reset clears valid bits and chain state at once; no clearing pass.
// The receiver cannot stall: rsp_valid lasts one cycle.
module seed_chain_accept #(
   parameter int TABLE_DEPTH      = 16,
   parameter int SMALL_QUANT_LOG2 = 6,
   parameter int LARGE_QUANT_LOG2 = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic        req_reverse,
   input  logic [15:0] req_seed_read_pos,
   input  logic [31:0] req_ref_pos,
   input  logic [15:0] req_first_read_base,
   input  logic [15:0] req_last_read_base,
   input  logic [31:0] req_first_ref_base,
   input  logic [31:0] req_last_ref_base,
   input  logic [15:0] req_seed_span,
   output logic        rsp_valid,
   output logic        rsp_accepted,
   output logic [2:0]  rsp_reject_reason,
   output logic [15:0] rsp_coverage,
   output logic [15:0] rsp_chain_first,
   output logic [15:0] rsp_chain_last,
   output logic        rsp_table_overflow,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [sca_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_DECIDE, ST_PRUNE, ST_WRITE, ST_DONE
   } state_type;

   // registers
   logic [19:0] half_bin_ff;
   logic [9:0]  max_radius_ff, max_diam_ff;
   logic [7:0]  ancient_ff, old_ff;

   state_type   state_ff;
   logic        nonempty_ff, chain_rev_ff;
   logic [31:0] init_diag_ff;
   logic [15:0] read_first_ff, read_last_ff, covered_ff;
   logic [31:0] ref_first_ff, ref_last_ff;
   logic [TABLE_DEPTH-1:0] valid_ff;

   logic [31:0] key_mem [TABLE_DEPTH];
   logic [15:0] off_mem [TABLE_DEPTH];
   logic [31:0] key_rd_ff;
   logic [15:0] off_rd_ff;

   // captured seed
   logic        rev_ff, first_ff;
   logic [15:0] pos_ff, fr_ff, lr_ff, span_ff;
   logic [31:0] fref_ff, lref_ff, diag_ff;

   logic [CW-1:0] addr_ff;     // read address issued
   logic [CW-1:0] chk_ff;      // entry whose data is in key_rd_ff
   logic          chk_vld_ff;
   logic          any_ff, diam_fail_ff;
   logic [31:0]   lo_ff, hi_ff;
   logic          hit_ff, free_ff;
   logic [IW-1:0] hit_idx_ff, free_idx_ff;
   logic [TABLE_DEPTH-1:0] keep_ff;

   logic          acc_ff, ovf_ff;
   logic [2:0]    rsn_ff;
   logic          rsp_valid_ff;

   // combinational helpers
   logic [31:0] diag_new;
   assign diag_new = req_reverse ? (req_ref_pos + {16'd0, req_seed_read_pos})
                                 : (req_ref_pos - {16'd0, req_seed_read_pos});

   logic [IW-1:0] chk_idx;
   assign chk_idx = chk_ff[IW-1:0];
   logic          chk_live;
   assign chk_live = chk_vld_ff && valid_ff[chk_idx];

   logic [16:0] pos_q;
   assign pos_q = {1'b0, pos_ff >> LARGE_QUANT_LOG2};
   logic [16:0] off_old, off_anc;
   assign off_old = {1'b0, off_rd_ff >> LARGE_QUANT_LOG2} + {9'd0, old_ff};
   assign off_anc = {1'b0, off_rd_ff >> LARGE_QUANT_LOG2} + {9'd0, ancient_ff};

   logic [32:0] dq, kq, dd;
   assign dq = {1'b0, diag_ff >> SMALL_QUANT_LOG2};
   assign kq = {1'b0, key_rd_ff >> SMALL_QUANT_LOG2};
   assign dd = (dq >= kq) ? dq - kq : kq - dq;

   // decision tests on captured seed and scan results
   logic [33:0] half_w, dlo, dhi, idg;
   assign half_w = (lr_ff < read_last_ff)
                 ? (34'(max_radius_ff) << SMALL_QUANT_LOG2) : {14'd0, half_bin_ff};
   assign idg = {2'b0, init_diag_ff};
   assign dlo = {2'b0, diag_ff} - half_w;   // may go negative: compare signed
   assign dhi = {2'b0, diag_ff} + half_w;
   logic band_fail;
   assign band_fail = ($signed(idg) <= $signed(dlo)) || ($signed(idg) >= $signed(dhi));

   logic age_fail;
   assign age_fail = ({1'b0, fr_ff >> LARGE_QUANT_LOG2} + {9'd0, ancient_ff})
                   < {1'b0, read_first_ff >> LARGE_QUANT_LOG2};

   logic [31:0] fref_sel, lref_sel;
   assign fref_sel = (read_first_ff > fr_ff) ? (chain_rev_ff ? lref_ff : fref_ff)
                                             : ref_first_ff;
   assign lref_sel = (read_last_ff < lr_ff) ? (chain_rev_ff ? fref_ff : lref_ff)
                                            : ref_last_ff;
   logic inv_fail;
   assign inv_fail = chain_rev_ff ? (fref_sel < lref_sel) : (fref_sel > lref_sel);

   logic rad_fail;
   assign rad_fail = ((dq + 33'(max_radius_ff)) < {1'b0, lo_ff >> SMALL_QUANT_LOG2})
                  || (({1'b0, hi_ff >> SMALL_QUANT_LOG2} + 33'(max_radius_ff)) < dq);

   logic [2:0] rsn_calc;
   always_comb begin
      if (rev_ff != chain_rev_ff)  rsn_calc = sca_pkg::RSN_ORIENT;
      else if (!any_ff)            rsn_calc = sca_pkg::RSN_ENDED;
      else if (band_fail)          rsn_calc = sca_pkg::RSN_BAND;
      else if (age_fail)           rsn_calc = sca_pkg::RSN_AGE;
      else if (inv_fail)           rsn_calc = sca_pkg::RSN_INVERT;
      else if (diam_fail_ff)       rsn_calc = sca_pkg::RSN_DIAM;
      else if (rad_fail)           rsn_calc = sca_pkg::RSN_RADIUS;
      else                         rsn_calc = sca_pkg::RSN_NONE;
   end

   // extent update
   function automatic logic [15:0] sat16(input logic [15:0] a, input logic [16:0] b);
      logic [17:0] s;
      s = {2'b0, a} + {1'b0, b};
      return (s > 18'hFFFF) ? 16'hFFFF : s[15:0];
   endfunction

   logic [15:0] cov_a, cov_b;
   always_comb begin
      if (first_ff) begin
         cov_a = sat16(covered_ff, {1'b0, span_ff});
         cov_b = cov_a;
      end else begin
         if (lr_ff < read_first_ff)
            cov_a = sat16(covered_ff, {1'b0, span_ff});
         else if (fr_ff < read_first_ff)
            cov_a = sat16(covered_ff, {1'b0, read_first_ff - fr_ff});
         else
            cov_a = covered_ff;
         if (fr_ff <= read_last_ff && read_last_ff < lr_ff)
            cov_b = sat16(cov_a, {1'b0, lr_ff - read_last_ff});
         else if (read_last_ff < fr_ff)
            cov_b = sat16(cov_a, {1'b0, span_ff});
         else
            cov_b = cov_a;
      end
   end

   // memory
   logic          mem_we;
   logic [IW-1:0] mem_wa;
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_wa] <= diag_ff;
         off_mem[mem_wa] <= pos_ff;
      end
      key_rd_ff <= key_mem[addr_ff[IW-1:0]];
      off_rd_ff <= off_mem[addr_ff[IW-1:0]];
   end

   logic [TABLE_DEPTH-1:0] keep_all;
   assign keep_all = keep_ff;
   assign mem_we = (state_ff == ST_WRITE) && (hit_ff || free_ff);
   assign mem_wa = hit_ff ? hit_idx_ff : free_idx_ff;

   // lowest free slot after pruning
   logic          free_any;
   logic [IW-1:0] free_first;
   always_comb begin
      free_any   = 1'b0;
      free_first = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (!(valid_ff[i] && keep_all[i])) begin
            free_any   = 1'b1;
            free_first = IW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         half_bin_ff   <= 20'd512;
         max_radius_ff <= 10'd8;
         max_diam_ff   <= 10'd16;
         ancient_ff    <= 8'd4;
         old_ff        <= 8'd2;
         nonempty_ff   <= 1'b0;
         chain_rev_ff  <= 1'b0;
         init_diag_ff  <= '0;
         read_first_ff <= 16'hFFFF;
         read_last_ff  <= '0;
         ref_first_ff  <= '0;
         ref_last_ff   <= '0;
         covered_ff    <= '0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         chk_vld_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               sca_pkg::CSR_DIAG_HALF_BIN: half_bin_ff   <= csr_data;
               sca_pkg::CSR_MAX_RADIUS:    max_radius_ff <= csr_data[9:0];
               sca_pkg::CSR_MAX_DIAMETER:  max_diam_ff   <= csr_data[9:0];
               sca_pkg::CSR_ANCIENT_AGE:   ancient_ff    <= csr_data[7:0];
               sca_pkg::CSR_OLD_AGE:       old_ff        <= csr_data[7:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               // busy stays up through the result word's cycle
               if (start && !rsp_valid_ff) begin
                  rev_ff     <= req_reverse;
                  pos_ff     <= req_seed_read_pos;
                  fr_ff      <= req_first_read_base;
                  lr_ff      <= req_last_read_base;
                  fref_ff    <= req_first_ref_base;
                  lref_ff    <= req_last_ref_base;
                  span_ff    <= req_seed_span;
                  diag_ff    <= nonempty_ff
                     ? (chain_rev_ff ? req_ref_pos + {16'd0, req_seed_read_pos}
                                     : req_ref_pos - {16'd0, req_seed_read_pos})
                     : diag_new;
                  first_ff   <= !nonempty_ff;
                  addr_ff    <= '0;
                  chk_vld_ff <= 1'b0;
                  any_ff       <= 1'b0;
                  diam_fail_ff <= 1'b0;
                  hit_ff       <= 1'b0;
                  keep_ff      <= '1;
                  if (!req_kind) begin
                     nonempty_ff   <= 1'b0;
                     chain_rev_ff  <= 1'b0;
                     init_diag_ff  <= '0;
                     read_first_ff <= 16'hFFFF;
                     read_last_ff  <= '0;
                     ref_first_ff  <= '0;
                     ref_last_ff   <= '0;
                     covered_ff    <= '0;
                     valid_ff      <= '0;
                     acc_ff        <= 1'b0;
                     ovf_ff        <= 1'b0;
                     rsn_ff        <= sca_pkg::RSN_NONE;
                     state_ff      <= ST_DONE;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               // one entry a cycle: diameter, extremes, and prune/match marks
               if (addr_ff < CW'(TABLE_DEPTH)) addr_ff <= addr_ff + 1'b1;
               chk_ff     <= addr_ff;
               chk_vld_ff <= addr_ff < CW'(TABLE_DEPTH);
               if (chk_live) begin
                  any_ff <= 1'b1;
                  if (!any_ff || key_rd_ff < lo_ff) lo_ff <= key_rd_ff;
                  if (!any_ff || key_rd_ff > hi_ff) hi_ff <= key_rd_ff;
                  if (off_old > pos_q && dd > 33'(max_diam_ff)) diam_fail_ff <= 1'b1;
                  if (off_anc < pos_q) keep_ff[chk_idx] <= 1'b0;
                  else if (key_rd_ff == diag_ff && !hit_ff) begin
                     hit_ff     <= 1'b1;
                     hit_idx_ff <= chk_idx;
                  end
               end
               if (chk_vld_ff && chk_ff == CW'(TABLE_DEPTH - 1)) state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               if (first_ff || rsn_calc == sca_pkg::RSN_NONE) begin
                  acc_ff  <= 1'b1;
                  rsn_ff  <= sca_pkg::RSN_NONE;
                  covered_ff <= cov_b;
                  if (first_ff) begin
                     nonempty_ff  <= 1'b1;
                     chain_rev_ff <= rev_ff;
                     init_diag_ff <= diag_ff;
                  end
                  if (first_ff || fr_ff < read_first_ff) begin
                     read_first_ff <= fr_ff;
                     ref_first_ff  <= (first_ff ? rev_ff : chain_rev_ff) ? lref_ff : fref_ff;
                  end
                  if (first_ff || lr_ff > read_last_ff) begin
                     read_last_ff <= lr_ff;
                     ref_last_ff  <= (first_ff ? rev_ff : chain_rev_ff) ? fref_ff : lref_ff;
                  end
                  state_ff <= ST_PRUNE;
               end else begin
                  acc_ff   <= 1'b0;
                  ovf_ff   <= 1'b0;
                  rsn_ff   <= rsn_calc;
                  state_ff <= ST_DONE;
               end
            end
            ST_PRUNE: begin
               free_ff     <= free_any;
               free_idx_ff <= free_first;
               valid_ff    <= valid_ff & keep_ff;
               state_ff    <= ST_WRITE;
            end
            ST_WRITE: begin
               ovf_ff <= !(hit_ff || free_ff);
               if (hit_ff || free_ff) valid_ff[mem_wa] <= 1'b1;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy               = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = acc_ff;
   assign rsp_reject_reason  = rsn_ff;
   assign rsp_coverage       = covered_ff;
   assign rsp_chain_first    = read_first_ff;
   assign rsp_chain_last     = read_last_ff;
   assign rsp_table_overflow = ovf_ff;

   a_rsp_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");
   a_acc_no_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_reject_reason == sca_pkg::RSN_NONE)
      else $error("accepted word carries a reason");
   a_ovf_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_overflow |-> rsp_accepted) else $error("overflow on reject");
   a_write_valid: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> valid_ff[$past(mem_wa)]) else $error("written entry not valid");

endmodule
